// ===== design/hbtr_pkg.sv =====
// Package for the Hamming best-two ratio matcher.
// Holds field widths, reset values, codes and the result snapshot type.
// No dependencies.
`default_nettype none

package hbtr_pkg;

  // Descriptor span carried on the stream and the part of it that is compared.
  localparam int DescWidth = 256;
  localparam int DescBits  = 256;
  localparam int MaxLines  = 1024;

  localparam int DistW   = 9;
  localparam int IdxW    = 10;
  localparam int CountW  = 16;
  localparam int RatioW  = 9;
  localparam int CfgIdxW = 1;

  localparam logic [DescWidth-1:0] DescMask = {DescWidth{1'b1}} >> (DescWidth - DescBits);

  localparam logic [DistW-1:0]  DistNone   = 9'd256;
  localparam logic [RatioW-1:0] RatioReset = 9'd154;
  localparam logic [DistW-1:0]  LimitReset = 9'd50;
  localparam logic [CountW-1:0] CountMax   = {CountW{1'b1}};

  // Item kinds carried in tuser.
  localparam logic OpStart = 1'b0;
  localparam logic OpCand  = 1'b1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgRatio = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgLimit = 1'b1;

  // Search state captured when an item closes a query.
  typedef struct packed {
    logic [IdxW-1:0]  query_id;
    logic             query_ok;
    logic [IdxW-1:0]  best_idx;
    logic [DistW-1:0] best_dist;
    logic [DistW-1:0] second_dist;
  } snap_t;

endpackage

`default_nettype wire

// ===== design/hamming_best_two_ratio_match.sv =====
// Top level of the Hamming best-two ratio matcher.
// Uses hbtr_pkg, hbtr_distance and hbtr_ratio_test.
//
// Usage. Items arrive on the s_axis channel. tuser selects the kind: a start
// item loads a 256-bit query descriptor, its identifier and its usable flag
// and clears the search; a candidate item is compared with the query by
// Hamming distance when its in-view flag is set. The block keeps the best and
// second-best distances and the index of the best candidate. An item with
// tlast set closes the search and yields one result on m_axis: the query
// identifier, the match decision, the best index, both distances and a
// saturating count of matches since reset. Items without tlast yield nothing.
//
// Throughput is one item per cycle while s_axis_tready is high. A closing
// item moves from the input register into the stage that holds the closed
// search while the ratio product is formed, and from there into the output
// register that drives m_axis. When the receiver stalls, the result waits in
// the output register and the middle stage; input items that do not close a
// search keep flowing, and s_axis_tready drops only when a closing item
// cannot move on. Reset clears the query, the search, the match count and
// all valid flags, and loads ratio_q8 = 154 and distance_limit = 50. The
// configuration port writes one register per cycle; the user must use it only
// while the block is idle, and the block itself does not enforce this.
`default_nettype none

module hamming_best_two_ratio_match (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata from bit 0: desc_word0, desc_word1, desc_word2, desc_word3 (256 bits),
  // query_usable (1), query_id (10), cand_index (10), cand_in_view (1), zero fill (2).
  input  wire logic [279:0] s_axis_tdata,
  // tuser: op (0 start, 1 candidate).
  input  wire logic        s_axis_tuser,
  // tlast: last.
  input  wire logic        s_axis_tlast,
  // Result stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata from bit 0: out_query_id (10), matched (1), best_index (10),
  // best_distance (9), second_distance (9), match_count (16), zero fill (1).
  output logic [55:0]      m_axis_tdata,
  // Configuration writes.
  input  wire logic        cfg_we_i,
  input  wire logic [hbtr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [hbtr_pkg::RatioW-1:0]  cfg_data_i
);

  // Configuration registers.
  logic [hbtr_pkg::RatioW-1:0] ratio_q8_q;
  logic [hbtr_pkg::DistW-1:0]  distance_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q8_q       <= hbtr_pkg::RatioReset;
      distance_limit_q <= hbtr_pkg::LimitReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hbtr_pkg::CfgRatio: ratio_q8_q       <= cfg_data_i;
        hbtr_pkg::CfgLimit: distance_limit_q <= cfg_data_i;
        default:            ratio_q8_q       <= ratio_q8_q;
      endcase
    end
  end

  // Input register.
  logic                           a_valid_q;
  logic                           a_op_q;
  logic                           a_last_q;
  logic [hbtr_pkg::DescWidth-1:0] a_desc_q;
  logic                           a_usable_q;
  logic [hbtr_pkg::IdxW-1:0]      a_qid_q;
  logic [hbtr_pkg::IdxW-1:0]      a_cidx_q;
  logic                           a_in_view_q;

  // Closed-search stage and output register.
  logic                           b_valid_q;
  hbtr_pkg::snap_t                b_snap_q;
  logic                           out_valid_q;
  logic [55:0]                    out_data_q;

  // Flow control: a stage moves when the one after it has room; non-closing input items always move.
  logic out_free, b_adv, b_free, a_adv, a_free, s_fire;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign b_adv         = b_valid_q && out_free;
  assign b_free        = !b_valid_q || out_free;
  assign a_adv         = a_valid_q && (!a_last_q || b_free);
  assign a_free        = !a_valid_q || a_adv;
  assign s_axis_tready = a_free;
  assign s_fire        = s_axis_tvalid && a_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (s_fire) begin
      a_valid_q <= 1'b1;
    end else if (a_adv) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      a_op_q      <= s_axis_tuser;
      a_last_q    <= s_axis_tlast;
      a_desc_q    <= s_axis_tdata[255:0];
      a_usable_q  <= s_axis_tdata[256];
      a_qid_q     <= s_axis_tdata[266:257];
      a_cidx_q    <= s_axis_tdata[276:267];
      a_in_view_q <= s_axis_tdata[277];
    end
  end

  // Query and search state.
  logic [hbtr_pkg::DescWidth-1:0] query_q, query_d;
  logic                           query_ok_q, query_ok_d;
  logic [hbtr_pkg::IdxW-1:0]      cur_qid_q, cur_qid_d;
  logic [hbtr_pkg::DistW-1:0]     best_q, best_d;
  logic [hbtr_pkg::DistW-1:0]     second_q, second_d;
  logic [hbtr_pkg::IdxW-1:0]      best_idx_q, best_idx_d;
  logic [hbtr_pkg::DistW-1:0]     cand_dist;
  logic                           cand_ok;

  hbtr_distance u_distance (
    .query_i (query_q),
    .cand_i  (a_desc_q),
    .dist_o  (cand_dist)
  );

  assign cand_ok = a_in_view_q && (32'(a_cidx_q) < hbtr_pkg::MaxLines);

  always_comb begin
    query_d    = query_q;
    query_ok_d = query_ok_q;
    cur_qid_d  = cur_qid_q;
    best_d     = best_q;
    second_d   = second_q;
    best_idx_d = best_idx_q;
    if (a_adv) begin
      if (a_op_q == hbtr_pkg::OpStart) begin
        query_d    = a_desc_q;
        query_ok_d = a_usable_q;
        cur_qid_d  = a_qid_q;
        best_d     = hbtr_pkg::DistNone;
        second_d   = hbtr_pkg::DistNone;
        best_idx_d = '0;
      end else if (cand_ok) begin
        // A tie with the best only tightens the second distance.
        if (cand_dist < best_q) begin
          second_d   = best_q;
          best_d     = cand_dist;
          best_idx_d = a_cidx_q;
        end else if (cand_dist < second_q) begin
          second_d = cand_dist;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_q    <= '0;
      query_ok_q <= 1'b0;
      cur_qid_q  <= '0;
      best_q     <= hbtr_pkg::DistNone;
      second_q   <= hbtr_pkg::DistNone;
      best_idx_q <= '0;
    end else begin
      query_q    <= query_d;
      query_ok_q <= query_ok_d;
      cur_qid_q  <= cur_qid_d;
      best_q     <= best_d;
      second_q   <= second_d;
      best_idx_q <= best_idx_d;
    end
  end

  // A closing item captures the search as it stands after that item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (a_adv && a_last_q) begin
      b_valid_q <= 1'b1;
    end else if (b_adv) begin
      b_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv && a_last_q) begin
      b_snap_q.query_id    <= cur_qid_d;
      b_snap_q.query_ok    <= query_ok_d;
      b_snap_q.best_idx    <= best_idx_d;
      b_snap_q.best_dist   <= best_d;
      b_snap_q.second_dist <= second_d;
    end
  end

  // Match decision and the saturating match count.
  logic                        matched;
  logic [hbtr_pkg::CountW-1:0] count_q, count_d;

  hbtr_ratio_test u_ratio_test (
    .snap_i           (b_snap_q),
    .ratio_q8_i       (ratio_q8_q),
    .distance_limit_i (distance_limit_q),
    .matched_o        (matched)
  );

  always_comb begin
    count_d = count_q;
    if (b_adv && matched && (count_q != hbtr_pkg::CountMax)) begin
      count_d = count_q + 16'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (b_adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_adv) begin
      out_data_q <= {1'b0, count_d, b_snap_q.second_dist, b_snap_q.best_dist,
                     b_snap_q.best_idx, matched, b_snap_q.query_id};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

// ===== design/hbtr_distance.sv =====
// Hamming distance between the stored query and one candidate descriptor.
// Byte popcounts feed a five-level adder tree. Uses hbtr_pkg.
`default_nettype none

module hbtr_distance (
  input  wire logic [hbtr_pkg::DescWidth-1:0] query_i,
  input  wire logic [hbtr_pkg::DescWidth-1:0] cand_i,
  output logic      [hbtr_pkg::DistW-1:0]     dist_o
);

  localparam int NBytes = hbtr_pkg::DescWidth / 8;

  logic [hbtr_pkg::DescWidth-1:0] diff;
  logic [3:0] lvl0 [NBytes];
  logic [4:0] lvl1 [NBytes/2];
  logic [5:0] lvl2 [NBytes/4];
  logic [6:0] lvl3 [NBytes/8];
  logic [7:0] lvl4 [NBytes/16];

  assign diff = (query_i ^ cand_i) & hbtr_pkg::DescMask;

  always_comb begin
    for (int i = 0; i < NBytes; i++) begin
      lvl0[i] = '0;
      for (int j = 0; j < 8; j++) begin
        lvl0[i] = lvl0[i] + 4'(diff[8*i+j]);
      end
    end
    for (int i = 0; i < NBytes/2; i++) begin
      lvl1[i] = 5'(lvl0[2*i]) + 5'(lvl0[2*i+1]);
    end
    for (int i = 0; i < NBytes/4; i++) begin
      lvl2[i] = 6'(lvl1[2*i]) + 6'(lvl1[2*i+1]);
    end
    for (int i = 0; i < NBytes/8; i++) begin
      lvl3[i] = 7'(lvl2[2*i]) + 7'(lvl2[2*i+1]);
    end
    for (int i = 0; i < NBytes/16; i++) begin
      lvl4[i] = 8'(lvl3[2*i]) + 8'(lvl3[2*i+1]);
    end
    dist_o = 9'(lvl4[0]) + 9'(lvl4[1]);
  end

endmodule

`default_nettype wire

// ===== design/hbtr_ratio_test.sv =====
// Match decision for one closed query: usable flag, distance limit and ratio test.
// Uses hbtr_pkg for the snapshot type and widths.
`default_nettype none

module hbtr_ratio_test (
  input  wire hbtr_pkg::snap_t               snap_i,
  input  wire logic [hbtr_pkg::RatioW-1:0]   ratio_q8_i,
  input  wire logic [hbtr_pkg::DistW-1:0]    distance_limit_i,
  output logic                               matched_o
);

  logic [17:0] lhs;
  logic [17:0] rhs;

  // best * 256 against ratio * second, both exact in 18 bits.
  assign lhs = {1'b0, snap_i.best_dist, 8'd0};
  assign rhs = 18'(ratio_q8_i) * 18'(snap_i.second_dist);

  assign matched_o = snap_i.query_ok
                   && (snap_i.best_dist < hbtr_pkg::DistNone)
                   && (snap_i.best_dist < distance_limit_i)
                   && (lhs <= rhs);

endmodule

`default_nettype wire
